/* sv/lthc_pkg.sv */
package lthc_pkg;

    localparam int CAPACITY = 64;
    localparam int RANK_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = 7;
    localparam int MAX_W    = 7;
    localparam int KEY_W    = 47;
    localparam int TEX_W    = 32;
    localparam int OP_W     = 2;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 80;

    typedef enum logic [OP_W-1:0] {
        OP_FIND   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RESOLVE,
        ST_ACT,
        ST_CHECK
    } state_t;

    typedef enum logic [1:0] {
        SM_KEY,
        SM_RANK,
        SM_FREE
    } smode_t;

    typedef enum logic [1:0] {
        RK_HOLD,
        RK_ZERO,
        RK_INC,
        RK_LAST
    } rank_op_t;

    typedef enum logic [2:0] {
        UPD_NONE,
        UPD_NEWEST,
        UPD_DROP,
        UPD_FILL,
        UPD_CLEAR
    } upd_t;

    typedef struct packed {
        logic     load;
        logic     search;
        logic     resolve;
        logic     set_final;
        smode_t   mode;
        op_t      op;
        rank_op_t rank_op;
        upd_t     upd;
        logic     tex_wr;
        logic     emit;
        logic     e_hit;
        logic     e_found;
        logic     e_freed;
        logic     e_last;
    } dp_cmd_t;

    typedef struct packed {
        logic hit;
        logic out_free;
        logic at_limit;
        logic evict_final;
        logic rank_last;
        logic empty;
    } dp_status_t;

endpackage

/* sv/lru_tile_handle_cache_unit.sv */
// fully associative lru table: tile key -> texture handle
// s_* carries requests: s_tuser is the opcode (find, insert, remove, clear),
// s_tdata the tile key and the handle to store. m_* carries results, one or
// more per request; m_tlast marks the final result of a request. each result
// shows hit, the found handle, a freed handle to release and the entry count
// after the request. cfg_* writes the entry limit (max_entries), always ready;
// write it only while the block is idle.
// one request is worked at a time and holds the block until it is done.
// find, remove and insert of a present key step through key compare against
// every entry, encode of the matching slot with the handle memory read, then
// update, when the result is loaded. insert of a new key then checks the
// limit, evicts the oldest entry by a rank search while at the limit and
// fills a free slot found by a search; clear does one rank search per held
// entry (one pass when empty); each step runs through the same stages.
// the next request is accepted once the current one is done, while its last
// result may still wait in the output register.
// a stalled m_tready holds the output register and pauses any request that
// still has results to give.
// reset empties the table, sets the limit to 64 and clears the output.
module lru_tile_handle_cache_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // tile_key[46:0], texture[78:47], zero fill
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // hit[0], found_texture[32:1], freed_valid[33],
                                   // freed_texture[65:34], entry_count[72:66], zero fill
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);
    import lthc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    op_t        in_op;

    assign in_op     = op_t'(s_tuser);
    assign cfg_ready = 1'b1;

    lthc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_op    (in_op),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lthc_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_value (cfg_data),
        .in_key    (s_tdata[KEY_W-1:0]),
        .in_tex    (s_tdata[KEY_W+TEX_W-1:KEY_W]),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

    // a new result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result emitted into a full output register");

    // one request at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.search, cmd.resolve, cmd.emit}))
        else $error("datapath steps overlap");

    // reported count never exceeds the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[72:66] <= COUNT_W'(CAPACITY)))
        else $error("entry count above capacity");

endmodule

/* sv/lthc_ctrl.sv */
module lthc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  lthc_pkg::op_t       in_op,
    output logic                in_ready,
    input  lthc_pkg::dp_status_t status,
    output lthc_pkg::dp_cmd_t   cmd
);
    import lthc_pkg::*;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    smode_t mode_reg, mode_next;
    logic   evicted_reg, evicted_next;
    logic   in_fire;
    logic   act_emits;
    logic   act_go;

    assign in_fire = in_valid && (state_reg == ST_IDLE);

    // insert produces no result on a key miss, nor on the fill after evictions
    assign act_emits = (state_reg == ST_ACT) &&
        !((op_reg == OP_INSERT) &&
          (((mode_reg == SM_KEY) && !status.hit) || ((mode_reg == SM_FREE) && evicted_reg)));
    assign act_go = (state_reg == ST_ACT) && (!act_emits || status.out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_FIND;
            mode_reg    <= SM_KEY;
            evicted_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            mode_reg    <= mode_next;
            evicted_reg <= evicted_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        mode_next    = mode_reg;
        evicted_next = evicted_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_next      = in_op;
                    evicted_next = 1'b0;
                    mode_next    = (in_op == OP_CLEAR) ? SM_RANK : SM_KEY;
                    state_next   = ST_SEARCH;
                end
            end
            ST_SEARCH:  state_next = ST_RESOLVE;
            ST_RESOLVE: state_next = ST_ACT;
            ST_ACT:
            begin
                if (act_go)
                begin
                    unique case (op_reg)
                        OP_FIND, OP_REMOVE: state_next = ST_IDLE;
                        OP_INSERT:
                        begin
                            unique case (mode_reg)
                                SM_KEY:  state_next = status.hit ? ST_IDLE : ST_CHECK;
                                SM_RANK:
                                begin
                                    evicted_next = 1'b1;
                                    state_next   = ST_CHECK;
                                end
                                default: state_next = ST_IDLE;
                            endcase
                        end
                        OP_CLEAR:
                            state_next = (status.empty || status.rank_last) ? ST_IDLE : ST_SEARCH;
                    endcase
                end
            end
            ST_CHECK:
            begin
                mode_next  = status.at_limit ? SM_RANK : SM_FREE;
                state_next = ST_SEARCH;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        cmd      = '0;
        cmd.op   = op_reg;
        cmd.mode = mode_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_fire;
                if (in_fire)
                    cmd.rank_op = RK_ZERO;
            end
            ST_SEARCH:  cmd.search = 1'b1;
            ST_RESOLVE:
            begin
                cmd.resolve   = 1'b1;
                cmd.set_final = (mode_reg == SM_KEY) || (op_reg == OP_CLEAR);
            end
            ST_ACT:
            begin
                if (act_go)
                begin
                    cmd.emit = act_emits;
                    unique case (op_reg)
                        OP_FIND:
                        begin
                            cmd.e_hit   = 1'b1;
                            cmd.e_found = status.hit;
                            cmd.e_last  = 1'b1;
                            cmd.upd     = status.hit ? UPD_NEWEST : UPD_NONE;
                        end
                        OP_REMOVE:
                        begin
                            cmd.e_hit   = 1'b1;
                            cmd.e_freed = status.hit;
                            cmd.e_last  = 1'b1;
                            cmd.upd     = status.hit ? UPD_DROP : UPD_NONE;
                        end
                        OP_INSERT:
                        begin
                            unique case (mode_reg)
                                SM_KEY:
                                begin
                                    cmd.e_hit   = 1'b1;
                                    cmd.e_freed = 1'b1;
                                    cmd.e_last  = 1'b1;
                                    cmd.tex_wr  = status.hit;
                                    cmd.upd     = status.hit ? UPD_NEWEST : UPD_NONE;
                                end
                                SM_RANK:
                                begin
                                    cmd.e_freed = 1'b1;
                                    cmd.e_last  = status.evict_final;
                                    cmd.upd     = UPD_DROP;
                                end
                                default:
                                begin
                                    cmd.e_last = 1'b1;
                                    cmd.tex_wr = 1'b1;
                                    cmd.upd    = UPD_FILL;
                                end
                            endcase
                        end
                        OP_CLEAR:
                        begin
                            if (status.empty)
                            begin
                                cmd.e_last = 1'b1;
                            end
                            else
                            begin
                                cmd.e_freed = 1'b1;
                                cmd.e_last  = status.rank_last;
                                if (status.rank_last)
                                    cmd.upd = UPD_CLEAR;
                                else
                                    cmd.rank_op = RK_INC;
                            end
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (status.at_limit)
                    cmd.rank_op = RK_LAST;
            end
            default: cmd = '0;
        endcase
    end

endmodule

/* sv/lthc_dpath.sv */
module lthc_dpath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [lthc_pkg::MAX_W-1:0]           cfg_value,
    input  logic [lthc_pkg::KEY_W-1:0]           in_key,
    input  logic [lthc_pkg::TEX_W-1:0]           in_tex,
    input  lthc_pkg::dp_cmd_t                    cmd,
    output lthc_pkg::dp_status_t                 status,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [lthc_pkg::OUT_TDATA_W-1:0]     out_data,
    output logic                                 out_last
);
    import lthc_pkg::*;

    logic [MAX_W-1:0]    max_entries_reg;
    logic [KEY_W-1:0]    key_in_reg;
    logic [TEX_W-1:0]    tex_in_reg;
    logic [CAPACITY-1:0] valid_reg;
    logic [KEY_W-1:0]    key_reg  [CAPACITY];
    logic [RANK_W-1:0]   rank_reg [CAPACITY];
    logic [TEX_W-1:0]    tex_mem  [CAPACITY];
    logic [TEX_W-1:0]    tex_q_reg;
    logic [CAPACITY-1:0] match_reg, match_next;
    logic [RANK_W-1:0]   slot_reg;
    logic [RANK_W-1:0]   slot_rank_reg;
    logic [RANK_W-1:0]   rank_sel_reg, rank_sel_next;
    logic                hit_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  final_reg, final_next;
    logic [COUNT_W-1:0]  lim;
    logic [COUNT_W-1:0]  count_m1;
    logic [RANK_W-1:0]   enc_idx;
    logic                match_any;

    logic                out_valid_reg;
    logic                o_hit_reg;
    logic [TEX_W-1:0]    o_found_reg;
    logic                o_fv_reg;
    logic [TEX_W-1:0]    o_ft_reg;
    logic [COUNT_W-1:0]  o_count_reg;
    logic                o_last_reg;

    function automatic logic [RANK_W-1:0] first_set(input logic [CAPACITY-1:0] v);
        logic [RANK_W-1:0] idx;
        idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
            if (v[i])
                idx = RANK_W'(i);
        return idx;
    endfunction

    // limit 0 behaves as 1, anything above capacity as capacity
    always_comb
    begin
        if (max_entries_reg == '0)
            lim = COUNT_W'(1);
        else if (max_entries_reg > MAX_W'(CAPACITY))
            lim = COUNT_W'(CAPACITY);
        else
            lim = COUNT_W'(max_entries_reg);
    end

    assign count_m1  = count_reg - COUNT_W'(1);
    assign enc_idx   = first_set(match_reg);
    assign match_any = |match_reg;

    assign status.hit         = hit_reg;
    assign status.out_free    = !out_valid_reg || out_ready;
    assign status.at_limit    = (count_reg >= lim);
    assign status.evict_final = (count_reg <= lim);
    assign status.rank_last   = (COUNT_W'(rank_sel_reg) == count_m1);
    assign status.empty       = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_entries_reg <= MAX_W'(CAPACITY);
        else if (cfg_we)
            max_entries_reg <= cfg_value;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_in_reg <= in_key;
            tex_in_reg <= in_tex;
        end
    end

    // per-entry compare, one match vector per search
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            case (cmd.mode)
                SM_KEY:  match_next[i] = valid_reg[i] && (key_reg[i] == key_in_reg);
                SM_RANK: match_next[i] = valid_reg[i] && (rank_reg[i] == rank_sel_reg);
                default: match_next[i] = !valid_reg[i];
            endcase
        end
    end

    always_comb
    begin
        case (cmd.rank_op)
            RK_ZERO: rank_sel_next = '0;
            RK_INC:  rank_sel_next = rank_sel_reg + RANK_W'(1);
            RK_LAST: rank_sel_next = RANK_W'(count_m1);
            default: rank_sel_next = rank_sel_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.op)
            OP_FIND:   final_next = count_reg;
            OP_INSERT: final_next = match_any ? count_reg :
                                    (status.at_limit ? lim : count_reg + COUNT_W'(1));
            OP_REMOVE: final_next = match_any ? count_m1 : count_reg;
            OP_CLEAR:  final_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        rank_sel_reg <= rank_sel_next;
        if (cmd.search)
            match_reg <= match_next;
        if (cmd.resolve)
        begin
            slot_reg      <= enc_idx;
            slot_rank_reg <= rank_reg[enc_idx];
            tex_q_reg     <= tex_mem[enc_idx];
            if (cmd.mode == SM_KEY)
                hit_reg <= match_any;
            if (cmd.set_final)
                final_reg <= final_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tex_wr)
            tex_mem[slot_reg] <= tex_in_reg;
    end

    always_ff @(posedge clk)
    begin
        case (cmd.upd)
            UPD_NEWEST:
            begin
                for (int i = 0; i < CAPACITY; i++)
                    if (valid_reg[i] && (rank_reg[i] < slot_rank_reg))
                        rank_reg[i] <= rank_reg[i] + RANK_W'(1);
                rank_reg[slot_reg] <= '0;
            end
            UPD_DROP:
            begin
                for (int i = 0; i < CAPACITY; i++)
                    if (valid_reg[i] && (rank_reg[i] > slot_rank_reg))
                        rank_reg[i] <= rank_reg[i] - RANK_W'(1);
            end
            UPD_FILL:
            begin
                for (int i = 0; i < CAPACITY; i++)
                    if (valid_reg[i])
                        rank_reg[i] <= rank_reg[i] + RANK_W'(1);
                rank_reg[slot_reg] <= '0;
                key_reg[slot_reg]  <= key_in_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            case (cmd.upd)
                UPD_DROP:
                begin
                    valid_reg[slot_reg] <= 1'b0;
                    count_reg           <= count_m1;
                end
                UPD_FILL:
                begin
                    valid_reg[slot_reg] <= 1'b1;
                    count_reg           <= count_reg + COUNT_W'(1);
                end
                UPD_CLEAR:
                begin
                    valid_reg <= '0;
                    count_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    // output register, loaded only when empty or being drained
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            o_hit_reg   <= cmd.e_hit && hit_reg;
            o_found_reg <= cmd.e_found ? tex_q_reg : '0;
            o_fv_reg    <= cmd.e_freed;
            o_ft_reg    <= cmd.e_freed ? tex_q_reg : '0;
            o_count_reg <= final_reg;
            o_last_reg  <= cmd.e_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_last  = o_last_reg;
    assign out_data  = {(OUT_TDATA_W - (2 * TEX_W + 2 + COUNT_W))'(0),
                        o_count_reg, o_ft_reg, o_fv_reg, o_found_reg, o_hit_reg};

endmodule
